FILE: rtl/assert_macros.svh
// Assertion helper macros for the bounded stack RTL.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BSBI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bsbi_pkg.sv
// Shared types and constants for the bounded stack with bottom increment.
// No dependencies.
package bsbi_pkg;

  localparam int unsigned DepthDef = 1024;
  localparam int unsigned CapW     = 11;
  localparam int unsigned WordW    = 32;
  localparam logic [CapW-1:0] CapReset = 11'd1024;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_INCR = 2'd2
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic        [1:0]       mode;
    logic signed [WordW-1:0] value;
    logic        [CapW-1:0]  count;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] popped_value;
    logic                    was_empty;
  } out_t;

  // Registered read data of both memories.
  typedef struct packed {
    logic [WordW-1:0] val;
    logic [WordW-1:0] inc_top;
    logic [WordW-1:0] inc_below;
  } mem_rsp_t;

endpackage

FILE: rtl/bsbi_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
// Payload type is a parameter; used with bsbi_pkg payload structs.
interface bsbi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bsbi_store.sv
// Entry and pending-add memories with synchronous, registered read ports.
// Depends on bsbi_pkg; request type comes from the top level.
module bsbi_store #(
  parameter int unsigned Depth = bsbi_pkg::DepthDef,
  parameter type         req_t = logic
) (
  input  logic               clk_i,
  input  req_t               req_i,
  output bsbi_pkg::mem_rsp_t rsp_o
);

  logic [bsbi_pkg::WordW-1:0] val_mem [Depth];
  logic [bsbi_pkg::WordW-1:0] inc_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.val_we) begin
      val_mem[req_i.waddr] <= req_i.val_wdata;
    end
    if (req_i.inc_we) begin
      inc_mem[req_i.waddr] <= req_i.inc_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_o.val       <= val_mem[req_i.raddr];
    rsp_o.inc_top   <= inc_mem[req_i.raddr];
    rsp_o.inc_below <= inc_mem[req_i.raddr_below];
  end

endmodule

FILE: rtl/bsbi_ctrl.sv
// Operation sequencer: fill count, capacity register, memory requests and
// result register. Depends on bsbi_pkg and bsbi_stream_if.
module bsbi_ctrl #(
  parameter int unsigned Depth = bsbi_pkg::DepthDef,
  parameter type         req_t = logic
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bsbi_pkg::CapW-1:0]   cfg_wdata_i,
  bsbi_stream_if.sink                 in_i,
  bsbi_stream_if.source               out_o,
  output req_t                        req_o,
  input  bsbi_pkg::mem_rsp_t          rsp_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FW = $clog2(Depth + 1);
  localparam int unsigned CW = (FW > bsbi_pkg::CapW) ? FW : bsbi_pkg::CapW;

  bsbi_pkg::state_e              state_q, state_d;
  logic [FW-1:0]                 fill_q, fill_d;
  logic [bsbi_pkg::CapW-1:0]     cap_q;
  logic                          pop_q, pop_d;
  logic                          empty_q, empty_d;
  logic [AW-1:0]                 addr_q, addr_d;
  logic [bsbi_pkg::WordW-1:0]    amt_q, amt_d;
  logic                          out_valid_q, out_valid_d;
  bsbi_pkg::out_t                out_data_q, out_data_d;

  logic                          accept;
  logic                          out_free;
  logic [CW-1:0]                 fill_x, cap_x, cnt_x, k_x;
  logic [AW-1:0]                 top_idx, k_idx;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign fill_x   = CW'(fill_q);
  assign cap_x    = CW'(cap_q);
  assign cnt_x    = CW'(in_i.data.count);
  assign k_x      = (cnt_x < fill_x) ? cnt_x : fill_x;
  assign top_idx  = AW'(fill_q - FW'(1));
  assign k_idx    = AW'(k_x - CW'(1));

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bsbi_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsbi_pkg::ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_q      <= pop_d;
    empty_q    <= empty_d;
    addr_q     <= addr_d;
    amt_q      <= amt_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    pop_d       = pop_q;
    empty_d     = empty_q;
    addr_d      = addr_q;
    amt_d       = amt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    in_i.ready  = 1'b0;

    req_o.raddr       = addr_q;
    req_o.raddr_below = addr_q - AW'(1);
    req_o.waddr       = addr_q;
    req_o.val_we      = 1'b0;
    req_o.val_wdata   = in_i.data.value;
    req_o.inc_we      = 1'b0;
    req_o.inc_wdata   = '0;

    unique case (state_q)
      bsbi_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        // Start the reads for a pop or increment in the accept cycle.
        req_o.raddr       = (in_i.data.mode == bsbi_pkg::MODE_INCR) ? k_idx : top_idx;
        req_o.raddr_below = req_o.raddr - AW'(1);
        if (accept) begin
          unique case (bsbi_pkg::mode_e'(in_i.data.mode))
            bsbi_pkg::MODE_PUSH: begin
              // New entry starts with no pending add.
              if (fill_x < cap_x && fill_q < FW'(Depth)) begin
                req_o.waddr  = AW'(fill_q);
                req_o.val_we = 1'b1;
                req_o.inc_we = 1'b1;
                fill_d       = fill_q + FW'(1);
              end
            end
            bsbi_pkg::MODE_POP: begin
              pop_d   = 1'b1;
              empty_d = (fill_q == '0);
              addr_d  = top_idx;
              if (fill_q != '0) begin
                fill_d = fill_q - FW'(1);
              end
              state_d = bsbi_pkg::ST_EXEC;
            end
            bsbi_pkg::MODE_INCR: begin
              if (k_x != '0) begin
                pop_d   = 1'b0;
                addr_d  = k_idx;
                amt_d   = in_i.data.value;
                state_d = bsbi_pkg::ST_EXEC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bsbi_pkg::ST_EXEC: begin
        if (!pop_q) begin
          req_o.inc_we    = 1'b1;
          req_o.inc_wdata = rsp_i.inc_top + amt_q;
          state_d         = bsbi_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = bsbi_pkg::ST_IDLE;
          if (empty_q) begin
            out_data_d.popped_value = -32'sd1;
            out_data_d.was_empty    = 1'b1;
          end else begin
            out_data_d.popped_value = rsp_i.val + rsp_i.inc_top;
            out_data_d.was_empty    = 1'b0;
            // Hand the pending add down to the new top.
            if (addr_q != '0) begin
              req_o.waddr     = addr_q - AW'(1);
              req_o.inc_we    = 1'b1;
              req_o.inc_wdata = rsp_i.inc_below + rsp_i.inc_top;
            end
          end
        end
      end
      default: begin
        state_d = bsbi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bounded_stack_with_bottom_increment.sv
// Bounded LIFO stack of signed 32-bit words with bottom-k increment.
// Channels: in_i takes one beat per operation (mode, value, count); out_o
// delivers one beat (popped_value, was_empty) for each pop, nothing for push,
// increment or the unused mode. The user must write capacity through cfg_we_i
// and cfg_wdata_i only while the block is idle; the block does not check it.
// Each entry keeps a lazy pending add; increment adds to the pending add of
// entry k-1, pop returns value plus pending add and passes the add down.
// Push, the unused mode and an increment whose clamped count is zero complete
// in ST_IDLE; pop and any other increment go on to ST_EXEC, a read of the
// memories followed by a write back of the pending-add memory, and in_i
// takes no new beat until the block is back in ST_IDLE. A pop loads its result
// beat into the result register in ST_EXEC, and if that register still holds
// an untaken beat, waits there until out_o.ready frees it; no beat is dropped.
// Reset clears the fill count and sets capacity to 1024; memory contents
// need no clearing, since only entries below the fill count are used.
`include "assert_macros.svh"

module bounded_stack_with_bottom_increment #(
  parameter int unsigned DEPTH = bsbi_pkg::DepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bsbi_pkg::CapW-1:0] cfg_wdata_i,
  bsbi_stream_if.sink               in_i,
  bsbi_stream_if.source             out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic [AW-1:0]                raddr;
    logic [AW-1:0]                raddr_below;
    logic [AW-1:0]                waddr;
    logic                         val_we;
    logic [bsbi_pkg::WordW-1:0]   val_wdata;
    logic                         inc_we;
    logic [bsbi_pkg::WordW-1:0]   inc_wdata;
  } mem_req_t;

  mem_req_t           mem_req;
  bsbi_pkg::mem_rsp_t mem_rsp;

  bsbi_ctrl #(
    .Depth (DEPTH),
    .req_t (mem_req_t)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .req_o       (mem_req),
    .rsp_i       (mem_rsp)
  );

  bsbi_store #(
    .Depth (DEPTH),
    .req_t (mem_req_t)
  ) u_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  `BSBI_ASSERT_IMPL(a_push_clears_add, mem_req.val_we, mem_req.inc_we && mem_req.inc_wdata == '0, "push must clear pending add")
  `BSBI_ASSERT_IMPL(a_val_write_on_push, mem_req.val_we, in_i.valid && in_i.ready && in_i.data.mode == bsbi_pkg::MODE_PUSH, "entry write without push beat")
  `BSBI_ASSERT_NEXT(a_pop_blocks_input, in_i.valid && in_i.ready && in_i.data.mode == bsbi_pkg::MODE_POP, !in_i.ready, "input taken during pop write back")

endmodule

FILE: tb/sv/bounded_stack_with_bottom_increment_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_stack_with_bottom_increment: directed and
// random push/pop/increment traffic against a behavioral stack mirror.
// Depends on bsbi_pkg, bsbi_stream_if and the top-level RTL.
module bounded_stack_with_bottom_increment_tb;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned SettleCycles = 8;

  // Mirror of the stack contents; queues the pop beats each op is due to produce.
  class stack_mirror;
    logic [bsbi_pkg::WordW-1:0] words [bsbi_pkg::DepthDef];
    int unsigned fill;
    int unsigned cap;
    bsbi_pkg::out_t pops_due [$];
    int errors;

    function new();
      fill = 0;
      cap = bsbi_pkg::CapReset;
      errors = 0;
    endfunction

    function void set_capacity(logic [bsbi_pkg::CapW-1:0] value);
      cap = value;
    endfunction

    function int pending();
      return pops_due.size();
    endfunction

    function void apply_op(bsbi_pkg::in_t op);
      int unsigned limit;
      int unsigned span;
      bsbi_pkg::out_t beat;
      case (op.mode)
        bsbi_pkg::MODE_PUSH: begin
          limit = (cap < bsbi_pkg::DepthDef) ? cap : bsbi_pkg::DepthDef;
          if (fill < limit) begin
            words[fill] = op.value;
            fill++;
          end
        end
        bsbi_pkg::MODE_POP: begin
          if (fill == 0) begin
            beat.popped_value = -32'sd1;
            beat.was_empty = 1'b1;
          end else begin
            fill--;
            beat.popped_value = words[fill];
            beat.was_empty = 1'b0;
          end
          pops_due = {pops_due, beat};
        end
        bsbi_pkg::MODE_INCR: begin
          span = (op.count > fill) ? fill : op.count;
          for (int unsigned i = 0; i < span; i++) words[i] = words[i] + op.value;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      errors++;
    endtask

    task check_pop(bsbi_pkg::out_t got);
      bsbi_pkg::out_t want;
      if (pops_due.size() == 0) begin
        report($sformatf("pop beat %0d/%0b with none outstanding",
                         got.popped_value, got.was_empty));
      end else begin
        want = pops_due.pop_front();
        if (got.popped_value !== want.popped_value)
          report($sformatf("popped_value got %0d want %0d",
                           got.popped_value, want.popped_value));
        if (got.was_empty !== want.was_empty)
          report($sformatf("was_empty got %0b want %0b", got.was_empty, want.was_empty));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [bsbi_pkg::CapW-1:0] cfg_wdata_i;
  int hold_seq = 0;
  int unsigned idle_cycles = 0;
  stack_mirror sb;

  bsbi_stream_if #(.payload_t(bsbi_pkg::in_t))  op_if ();
  bsbi_stream_if #(.payload_t(bsbi_pkg::out_t)) pop_if ();

  bounded_stack_with_bottom_increment u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (op_if),
    .out_o      (pop_if)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic bsbi_pkg::in_t make_op(logic [1:0] mode,
                                            logic [bsbi_pkg::WordW-1:0] value,
                                            logic [bsbi_pkg::CapW-1:0] count);
    bsbi_pkg::in_t op;
    op.mode = mode;
    op.value = value;
    op.count = count;
    return op;
  endfunction

  function automatic logic [bsbi_pkg::WordW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bsbi_pkg::CapW-1:0] rand_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 11'd2047;
      2: return bsbi_pkg::CapW'($urandom_range(0, 2047));
      default: return bsbi_pkg::CapW'($urandom_range(0, sb.fill + 2));
    endcase
  endfunction

  function automatic bsbi_pkg::in_t rand_op(int push_w, int pop_w, int incr_w);
    bsbi_pkg::in_t op;
    int pick;
    op.value = rand_word();
    op.count = rand_count();
    pick = $urandom_range(0, push_w + pop_w + incr_w - 1);
    if ($urandom_range(0, 49) == 0) op.mode = ModeUnused;
    else if (pick < push_w) op.mode = bsbi_pkg::MODE_PUSH;
    else if (pick < push_w + pop_w) op.mode = bsbi_pkg::MODE_POP;
    else op.mode = bsbi_pkg::MODE_INCR;
    return op;
  endfunction

  // Offer one beat and hold it until taken; valid stays high for the next beat.
  task automatic send_item(bsbi_pkg::in_t op);
    @(negedge clk_i);
    op_if.valid = 1'b1;
    op_if.data = op;
    do @(posedge clk_i); while (!op_if.ready);
    sb.apply_op(op);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      op_if.valid = 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write capacity only once the block has gone quiet.
  task automatic set_capacity(logic [bsbi_pkg::CapW-1:0] value);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic run_phase(int n_items, int push_w, int pop_w, int incr_w, int gap_max);
    bsbi_pkg::in_t op;
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        op = rand_op(push_w, pop_w, incr_w);
        send_item(op);
        if (op.mode != ModeUnused) sent++;
      end
      idle_input($urandom_range(0, gap_max));
    end
  endtask

  // Receiver: switch between stall styles; honor a long hold-off on request.
  initial begin
    int left;
    int style;
    int tick;
    int seen;
    left = 0;
    style = 0;
    tick = 0;
    seen = 0;
    pop_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != seen) begin
        seen = hold_seq;
        pop_if.ready = 1'b0;
        for (int c = 1; c < HoldOffCycles; c++) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        tick++;
        case (style)
          0: pop_if.ready = 1'b1;
          1: pop_if.ready = $urandom_range(0, 1);
          2: pop_if.ready = ($urandom_range(0, 3) != 0);
          default: pop_if.ready = ((tick % 8) >= 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop_if.valid && pop_if.ready) sb.check_pop(pop_if.data);
  end

  always @(posedge clk_i) begin
    if ((op_if.valid && op_if.ready) || (pop_if.valid && pop_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("bounded_stack_with_bottom_increment: mismatch");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    op_if.valid = 1'b0;
    op_if.data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty stack, word extremes, clamped and zero counts, unused mode.
    send_item(make_op(bsbi_pkg::MODE_POP, 32'h0, 11'd0));
    send_item(make_op(bsbi_pkg::MODE_INCR, 32'd5, 11'd3));
    send_item(make_op(bsbi_pkg::MODE_PUSH, 32'h7FFF_FFFF, 11'd0));
    send_item(make_op(bsbi_pkg::MODE_PUSH, 32'h8000_0000, 11'd2047));
    send_item(make_op(bsbi_pkg::MODE_PUSH, 32'hFFFF_FFFF, 11'd0));
    send_item(make_op(bsbi_pkg::MODE_PUSH, 32'h0, 11'd0));
    send_item(make_op(bsbi_pkg::MODE_INCR, 32'd1, 11'd2047));
    send_item(make_op(bsbi_pkg::MODE_INCR, 32'h8000_0000, 11'd1));
    send_item(make_op(bsbi_pkg::MODE_INCR, 32'd7, 11'd0));
    send_item(make_op(ModeUnused, 32'hAAAA_5555, 11'd5));
    repeat (5) send_item(make_op(bsbi_pkg::MODE_POP, 32'h0, 11'd0));

    // Capacity one: second push drops.
    set_capacity(11'd1);
    send_item(make_op(bsbi_pkg::MODE_PUSH, 32'd11, 11'd0));
    send_item(make_op(bsbi_pkg::MODE_PUSH, 32'd22, 11'd0));
    send_item(make_op(bsbi_pkg::MODE_POP, 32'h0, 11'd0));
    send_item(make_op(bsbi_pkg::MODE_POP, 32'h0, 11'd0));

    // Capacity zero: every push drops.
    set_capacity(11'd0);
    send_item(make_op(bsbi_pkg::MODE_PUSH, 32'd33, 11'd0));
    send_item(make_op(bsbi_pkg::MODE_POP, 32'h0, 11'd0));

    // Capacity above the depth: fill to the physical limit and beyond.
    set_capacity(11'd2047);
    run_phase(1070, 98, 0, 2, 3);
    run_phase(60, 40, 40, 20, 4);

    // Long output hold-off while pops keep coming: input must back up.
    set_capacity(11'd8);
    @(posedge clk_i);
    hold_seq++;
    run_phase(120, 30, 60, 10, 2);

    set_capacity(11'd1);
    run_phase(50, 45, 45, 10, 5);
    set_capacity(bsbi_pkg::CapW'($urandom_range(1, 40)));
    run_phase(60, 40, 40, 20, 6);
    set_capacity(11'd0);
    run_phase(20, 40, 40, 20, 3);
    set_capacity(11'd1024);
    run_phase(50, 45, 40, 15, 0);

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d pop beats never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("bounded_stack_with_bottom_increment: match");
    end else begin
      $display("bounded_stack_with_bottom_increment: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bsbi_pkg.sv
rtl/bsbi_stream_if.sv
rtl/bsbi_store.sv
rtl/bsbi_ctrl.sv
rtl/bounded_stack_with_bottom_increment.sv
tb/sv/bounded_stack_with_bottom_increment_tb.sv
